>>> rtl/core/generational_slot_map_top_assert.svh
// Assertion macros used by the checker of the slot map.
`ifndef GENERATIONAL_SLOT_MAP_TOP_ASSERT_SVH
`define GENERATIONAL_SLOT_MAP_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define GSM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define GSM_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/core/gsm_pkg.sv
package gsm_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int GEN_WIDTH  = 16;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int LINK_W     = SLOT_W + 1;
   localparam int COUNT_W    = SLOT_W + 1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_MOVE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic move;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic move_needed;
      logic rsp_busy;
   } stat_type;

endpackage

>>> rtl/core/gsm_ram.sv
module gsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gsm_ctrl.sv
module gsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gsm_pkg::stat_type  stat,
   output gsm_pkg::ctrl_type  ctrl
);

   gsm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gsm_pkg::S_IDLE: begin
            if (req_valid) state_in = gsm_pkg::S_EXEC;
         end
         gsm_pkg::S_EXEC: begin
            state_in = stat.move_needed ? gsm_pkg::S_MOVE : gsm_pkg::S_DONE;
         end
         gsm_pkg::S_MOVE: begin
            state_in = gsm_pkg::S_DONE;
         end
         gsm_pkg::S_DONE: begin
            if (!stat.rsp_busy) state_in = gsm_pkg::S_IDLE;
         end
         default: begin
            state_in = gsm_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         gsm_pkg::S_IDLE: begin
            req_ready = !reset;
            ctrl.load = req_valid && !reset;
         end
         gsm_pkg::S_EXEC: begin
            ctrl.exec = 1'b1;
         end
         gsm_pkg::S_MOVE: begin
            ctrl.move = 1'b1;
         end
         gsm_pkg::S_DONE: begin
            ctrl.finish = !stat.rsp_busy;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

>>> rtl/core/gsm_datapath.sv
module gsm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gsm_pkg::ctrl_type                    ctrl,
   output gsm_pkg::stat_type                    stat,
   input  logic [1:0]                           req_command,
   input  logic [gsm_pkg::SLOT_W-1:0]           req_key_slot,
   input  logic [gsm_pkg::GEN_WIDTH-1:0]        req_key_generation,
   input  logic [gsm_pkg::DATA_WIDTH-1:0]       req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [gsm_pkg::SLOT_W-1:0]           rsp_handle_slot,
   output logic [gsm_pkg::GEN_WIDTH-1:0]        rsp_handle_generation,
   output logic [gsm_pkg::COUNT_W-1:0]          rsp_count
);

   localparam int SW = gsm_pkg::SLOT_W;
   localparam int LW = gsm_pkg::LINK_W;
   localparam int CW = gsm_pkg::COUNT_W;
   localparam int GW = gsm_pkg::GEN_WIDTH;
   localparam int DW = gsm_pkg::DATA_WIDTH;
   localparam int N  = gsm_pkg::CAPACITY;

   gsm_pkg::cmd_type    cmd_ff;
   logic [SW-1:0]       ks_ff;
   logic [GW-1:0]       kg_ff;
   logic [DW-1:0]       val_ff;
   logic [LW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [GW-1:0]       gc_ff, gc_in;
   logic [N-1:0]        occ_ff, occ_in;
   logic [N-1:0]        link_vld_ff, link_vld_in;
   logic [N-1:0]        gen_vld_ff, gen_vld_in;
   logic                link_vrd_ff, gen_vrd_ff;
   logic [LW-1:0]       d_ff, d_in;
   gsm_pkg::status_type st_ff, st_in;
   logic [SW-1:0]       hs_ff, hs_in;
   logic [GW-1:0]       hg_ff, hg_in;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [SW-1:0]       rsp_slot_ff;
   logic [GW-1:0]       rsp_gen_ff;
   logic [CW-1:0]       rsp_count_ff;

   logic                link_we, gen_we, dense_we;
   logic [SW-1:0]       link_waddr, link_raddr, gen_waddr, dense_waddr, last_addr;
   logic [LW-1:0]       link_wdata, link_rdata, link_eff;
   logic [GW-1:0]       gen_wdata, gen_rdata, gen_eff;
   logic [DW-1:0]       val_wdata, val_rdata;
   logic [SW-1:0]       own_wdata, own_rdata;
   logic                insert_ok, handle_live, do_move;

   assign link_raddr = (gsm_pkg::cmd_type'(req_command) == gsm_pkg::CMD_INSERT) ?
                       head_ff[SW-1:0] : req_key_slot;
   assign last_addr  = count_ff[SW-1:0] - SW'(1);
   assign link_eff   = link_vrd_ff ? link_rdata : ({1'b0, ks_ff} + LW'(1));
   assign gen_eff    = gen_vrd_ff ? gen_rdata : '0;
   assign insert_ok  = (count_ff < CW'(N)) && (head_ff < LW'(N));
   assign handle_live = occ_ff[ks_ff] && (gen_eff == kg_ff) && (count_ff != '0);
   assign do_move    = (d_ff != {1'b0, last_addr}) && (d_ff < LW'(N));

   assign stat.move_needed = (cmd_ff == gsm_pkg::CMD_ERASE) && handle_live;
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_ready;

   gsm_ram #(.WIDTH(LW), .DEPTH(N)) u_link (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(link_raddr), .rd_data(link_rdata)
   );

   gsm_ram #(.WIDTH(GW), .DEPTH(N)) u_gen (
      .clock(clock), .wr_en(gen_we), .wr_addr(gen_waddr), .wr_data(gen_wdata),
      .rd_addr(req_key_slot), .rd_data(gen_rdata)
   );

   gsm_ram #(.WIDTH(DW), .DEPTH(N)) u_values (
      .clock(clock), .wr_en(dense_we), .wr_addr(dense_waddr), .wr_data(val_wdata),
      .rd_addr(last_addr), .rd_data(val_rdata)
   );

   gsm_ram #(.WIDTH(SW), .DEPTH(N)) u_owner (
      .clock(clock), .wr_en(dense_we), .wr_addr(dense_waddr), .wr_data(own_wdata),
      .rd_addr(last_addr), .rd_data(own_rdata)
   );

   always_comb begin
      link_we     = 1'b0;
      link_waddr  = head_ff[SW-1:0];
      link_wdata  = count_ff;
      gen_we      = 1'b0;
      gen_waddr   = head_ff[SW-1:0];
      gen_wdata   = gc_ff;
      dense_we    = 1'b0;
      dense_waddr = count_ff[SW-1:0];
      val_wdata   = val_ff;
      own_wdata   = head_ff[SW-1:0];
      head_in     = head_ff;
      count_in    = count_ff;
      gc_in       = gc_ff;
      occ_in      = occ_ff;
      link_vld_in = link_vld_ff;
      gen_vld_in  = gen_vld_ff;
      d_in        = d_ff;
      st_in       = st_ff;
      hs_in       = hs_ff;
      hg_in       = hg_ff;
      if (ctrl.exec) begin
         st_in = gsm_pkg::ST_OK;
         hs_in = '0;
         hg_in = '0;
         case (cmd_ff)
            gsm_pkg::CMD_INSERT: begin
               if (!insert_ok) begin
                  st_in = gsm_pkg::ST_FULL;
               end else begin
                  link_we  = 1'b1;
                  gen_we   = 1'b1;
                  dense_we = 1'b1;
                  link_vld_in[head_ff[SW-1:0]] = 1'b1;
                  gen_vld_in[head_ff[SW-1:0]]  = 1'b1;
                  occ_in[head_ff[SW-1:0]]      = 1'b1;
                  head_in  = link_vrd_ff ? link_rdata : (head_ff + LW'(1));
                  count_in = count_ff + CW'(1);
                  gc_in    = gc_ff + GW'(1);
                  hs_in    = head_ff[SW-1:0];
                  hg_in    = gc_ff;
               end
            end
            gsm_pkg::CMD_ERASE: begin
               if (!handle_live) begin
                  st_in = gsm_pkg::ST_INVALID;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = ks_ff;
                  link_wdata = head_ff;
                  gen_we     = 1'b1;
                  gen_waddr  = ks_ff;
                  link_vld_in[ks_ff] = 1'b1;
                  gen_vld_in[ks_ff]  = 1'b1;
                  occ_in[ks_ff]      = 1'b0;
                  head_in = {1'b0, ks_ff};
                  d_in    = link_eff;
                  gc_in   = gc_ff + GW'(1);
               end
            end
            gsm_pkg::CMD_CHECK: begin
               st_in = handle_live ? gsm_pkg::ST_OK : gsm_pkg::ST_INVALID;
            end
            gsm_pkg::CMD_CLEAR: begin
               occ_in      = '0;
               link_vld_in = '0;
               head_in     = '0;
               count_in    = '0;
            end
            default: begin
               st_in = gsm_pkg::ST_OK;
            end
         endcase
      end
      if (ctrl.move) begin
         count_in = count_ff - CW'(1);
         if (do_move) begin
            dense_we    = 1'b1;
            dense_waddr = d_ff[SW-1:0];
            val_wdata   = val_rdata;
            own_wdata   = own_rdata;
            link_we     = 1'b1;
            link_waddr  = own_rdata;
            link_wdata  = d_ff;
            link_vld_in[own_rdata] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         gc_ff        <= '0;
         occ_ff       <= '0;
         link_vld_ff  <= '0;
         gen_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         gc_ff       <= gc_in;
         occ_ff      <= occ_in;
         link_vld_ff <= link_vld_in;
         gen_vld_ff  <= gen_vld_in;
         if (ctrl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff      <= gsm_pkg::cmd_type'(req_command);
         ks_ff       <= req_key_slot;
         kg_ff       <= req_key_generation;
         val_ff      <= req_value;
         link_vrd_ff <= link_vld_ff[link_raddr];
         gen_vrd_ff  <= gen_vld_ff[req_key_slot];
      end
      d_ff  <= d_in;
      st_ff <= st_in;
      hs_ff <= hs_in;
      hg_ff <= hg_in;
      if (ctrl.finish) begin
         rsp_status_ff <= st_ff;
         rsp_slot_ff   <= hs_ff;
         rsp_gen_ff    <= hg_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_handle_slot       = rsp_slot_ff;
   assign rsp_handle_generation = rsp_gen_ff;
   assign rsp_count             = rsp_count_ff;

endmodule

>>> rtl/core/generational_slot_map_top.sv
// Generational slot map with 64 slots. Each request word (insert, erase, check or clear)
// gives one response word. Each word is accepted in the idle state and passes through the
// execute and done states; an erase of a live handle also passes through the move state
// between them. The response register is loaded as the done state ends. The slot tables
// sit in memories with a registered read. Erase needs a second dependent read of the last
// dense entry before it can fill the hole. The response register holds a finished word
// while the next request is accepted. A request waits in its final cycle only while that
// register is still full. The request side is not ready while reset is high. Tables are
// ready right after reset, with no clearing pass.
module generational_slot_map_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_command,
   input  logic [gsm_pkg::SLOT_W-1:0]           req_key_slot,
   input  logic [gsm_pkg::GEN_WIDTH-1:0]        req_key_generation,
   input  logic [gsm_pkg::DATA_WIDTH-1:0]       req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [gsm_pkg::SLOT_W-1:0]           rsp_handle_slot,
   output logic [gsm_pkg::GEN_WIDTH-1:0]        rsp_handle_generation,
   output logic [gsm_pkg::COUNT_W-1:0]          rsp_count
);

   gsm_pkg::ctrl_type ctrl;
   gsm_pkg::stat_type stat;

   gsm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .ctrl(ctrl)
   );

   gsm_datapath u_datapath (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_command(req_command), .req_key_slot(req_key_slot),
      .req_key_generation(req_key_generation), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_handle_slot(rsp_handle_slot), .rsp_handle_generation(rsp_handle_generation),
      .rsp_count(rsp_count)
   );

endmodule

>>> rtl/core/gsm_checker.sv
`include "generational_slot_map_top_assert.svh"

module gsm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [1:0]                           rsp_status,
   input logic [gsm_pkg::SLOT_W-1:0]           rsp_handle_slot,
   input logic [gsm_pkg::GEN_WIDTH-1:0]        rsp_handle_generation,
   input logic [gsm_pkg::COUNT_W-1:0]          rsp_count
);

   logic stalled;
   logic status_legal;
   logic count_legal;
   logic handle_clear;

   assign stalled      = rsp_valid && !rsp_ready;
   assign status_legal = (rsp_status == gsm_pkg::ST_OK) || (rsp_status == gsm_pkg::ST_FULL) ||
                         (rsp_status == gsm_pkg::ST_INVALID);
   assign count_legal  = rsp_count <= gsm_pkg::COUNT_W'(gsm_pkg::CAPACITY);
   assign handle_clear = (rsp_status == gsm_pkg::ST_OK) ||
                         (rsp_handle_slot == '0 && rsp_handle_generation == '0);

   `GSM_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_count), "word dropped in stall")
   `GSM_ASSERT_ALWAYS(a_status_code, !rsp_valid || status_legal, "illegal status code")
   `GSM_ASSERT_ALWAYS(a_count_range, !rsp_valid || count_legal, "count beyond capacity")
   `GSM_ASSERT_ALWAYS(a_handle_zero, !rsp_valid || handle_clear, "handle on a failed operation")

endmodule

bind generational_slot_map_top gsm_checker u_gsm_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_status(rsp_status), .rsp_handle_slot(rsp_handle_slot),
   .rsp_handle_generation(rsp_handle_generation), .rsp_count(rsp_count)
);

>>> sim/tb_top.sv
module tb_top;
   import gsm_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_command = CMD_CHECK;
   logic [SLOT_W-1:0]     req_key_slot = '0;
   logic [GEN_WIDTH-1:0]  req_key_generation = '0;
   logic [DATA_WIDTH-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic [SLOT_W-1:0]     rsp_handle_slot;
   logic [GEN_WIDTH-1:0]  rsp_handle_generation;
   logic [COUNT_W-1:0]    rsp_count;

   typedef struct packed {
      logic [1:0]           status;
      logic [SLOT_W-1:0]    hslot;
      logic [GEN_WIDTH-1:0] hgen;
      logic [COUNT_W-1:0]   count;
   } answer_type;

   answer_type            answers_due[$];
   int                    error_count = 0;
   int                    word_count = 0;
   int                    answer_count = 0;
   int                    insert_ok_count = 0;
   int                    erase_ok_count = 0;
   int                    full_count = 0;
   int                    invalid_count = 0;
   int                    rsp_wait = 0;

   logic [LINK_W-1:0]     map_link [CAPACITY];
   logic [GEN_WIDTH-1:0]  map_gen [CAPACITY];
   logic                  map_used [CAPACITY];
   logic [DATA_WIDTH-1:0] dense_val [CAPACITY];
   logic [SLOT_W-1:0]     dense_slot [CAPACITY];
   logic [LINK_W-1:0]     map_free;
   logic [COUNT_W-1:0]    map_count;
   logic [GEN_WIDTH-1:0]  map_stamp;

   generational_slot_map_top uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void rebuild_free_list();
      for (int i = 0; i < CAPACITY; i++) begin
         map_link[i] = LINK_W'(i + 1);
         map_used[i] = 1'b0;
      end
      map_free = '0;
      map_count = '0;
   endfunction

   function automatic logic is_live(logic [SLOT_W-1:0] s, logic [GEN_WIDTH-1:0] g);
      return map_used[s] && map_gen[s] == g;
   endfunction

   function automatic answer_type apply_command(cmd_type cmd, logic [SLOT_W-1:0] ks,
                                                logic [GEN_WIDTH-1:0] kg,
                                                logic [DATA_WIDTH-1:0] val);
      answer_type a;
      logic [SLOT_W-1:0] s;
      logic [COUNT_W-1:0] d;
      logic [COUNT_W-1:0] last;
      logic [SLOT_W-1:0] owner;
      a = '0;
      a.status = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (map_count >= CAPACITY || map_free >= CAPACITY) begin
               a.status = ST_FULL;
               full_count++;
            end else begin
               s = map_free[SLOT_W-1:0];
               d = map_count;
               map_free = map_link[s];
               map_link[s] = d;
               map_gen[s] = map_stamp;
               map_used[s] = 1'b1;
               dense_val[d[SLOT_W-1:0]] = val;
               dense_slot[d[SLOT_W-1:0]] = s;
               map_count = d + COUNT_W'(1);
               a.hslot = s;
               a.hgen = map_stamp;
               map_stamp = map_stamp + GEN_WIDTH'(1);
               insert_ok_count++;
            end
         end
         CMD_ERASE: begin
            if (!is_live(ks, kg) || map_count == 0) begin
               a.status = ST_INVALID;
               invalid_count++;
            end else begin
               d = map_link[ks];
               last = map_count - COUNT_W'(1);
               map_link[ks] = map_free;
               map_gen[ks] = map_stamp;
               map_used[ks] = 1'b0;
               map_free = {1'b0, ks};
               if (d != last && d < CAPACITY) begin
                  owner = dense_slot[last[SLOT_W-1:0]];
                  dense_val[d[SLOT_W-1:0]] = dense_val[last[SLOT_W-1:0]];
                  dense_slot[d[SLOT_W-1:0]] = owner;
                  map_link[owner] = d;
               end
               map_count = last;
               map_stamp = map_stamp + GEN_WIDTH'(1);
               erase_ok_count++;
            end
         end
         CMD_CHECK: begin
            if (!is_live(ks, kg)) begin
               a.status = ST_INVALID;
               invalid_count++;
            end
         end
         default: rebuild_free_list();
      endcase
      a.count = map_count;
      return a;
   endfunction

   // The request stays valid after acceptance until the next word or a pause takes over.
   task automatic send_word(cmd_type cmd, logic [SLOT_W-1:0] ks,
                            logic [GEN_WIDTH-1:0] kg, logic [DATA_WIDTH-1:0] val);
      int gap;
      answer_type due;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key_slot <= ks;
      req_key_generation <= kg;
      req_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = apply_command(cmd, ks, kg, val);
      answers_due = {answers_due, due};
      word_count++;
   endtask

   // Picks a handle that is live most of the time, else a stale or random one.
   task automatic send_handle_op(cmd_type cmd);
      int pick;
      logic [SLOT_W-1:0] s;
      logic [GEN_WIDTH-1:0] g;
      s = SLOT_W'($urandom);
      g = GEN_WIDTH'($urandom);
      pick = $urandom_range(0, 9);
      if (map_count != 0 && pick < 7) begin
         s = dense_slot[$urandom_range(0, map_count - 1)];
         g = map_gen[s];
      end else if (pick < 9) begin
         g = map_gen[s] ^ GEN_WIDTH'(pick == 8 ? 0 : 1 << $urandom_range(0, GEN_WIDTH - 1));
      end
      send_word(cmd, s, g, DATA_WIDTH'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_ops();
      send_word(CMD_CHECK, '0, '0, '0);
      send_word(CMD_ERASE, '0, '0, '0);
      send_word(CMD_INSERT, '0, '0, '0);
      send_word(CMD_INSERT, '1, '1, '1);
      send_word(CMD_CHECK, 6'd0, 16'd0, '0);
      send_word(CMD_CHECK, 6'd1, 16'd1, '0);
      send_word(CMD_CHECK, 6'd1, 16'd0, '0);
      send_word(CMD_ERASE, 6'd0, 16'd0, '0);
      send_word(CMD_ERASE, 6'd0, 16'd0, '0);
      send_word(CMD_CHECK, '1, '1, '0);
      send_word(CMD_INSERT, '0, '0, 32'h5555_AAAA);
      send_word(CMD_CLEAR, '1, '1, '1);
      send_word(CMD_CHECK, 6'd1, 16'd1, '0);
      wait_drained();
   endtask

   task automatic test_fill_and_drain();
      repeat (CAPACITY + 2) send_word(CMD_INSERT, '0, '0, DATA_WIDTH'($urandom));
      repeat (CAPACITY + 4) send_handle_op(CMD_ERASE);
      send_word(CMD_CLEAR, '0, '0, '0);
   endtask

   task automatic test_random_mix(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) send_word(CMD_INSERT, SLOT_W'($urandom), GEN_WIDTH'($urandom),
                               DATA_WIDTH'($urandom));
         else if (r < 70) send_handle_op(CMD_ERASE);
         else if (r < 98) send_handle_op(CMD_CHECK);
         else send_word(CMD_CLEAR, SLOT_W'($urandom), GEN_WIDTH'($urandom),
                        DATA_WIDTH'($urandom));
         if (i == n / 2) wait_drained();
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answer_count++;
            if (answers_due.size() == 0) begin
               $error("Response word with no request pending");
               error_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_handle_slot !== want.hslot) begin
                  $error("handle_slot: expected %0d, got %0d", want.hslot, rsp_handle_slot);
                  error_count++;
               end
               if (rsp_handle_generation !== want.hgen) begin
                  $error("handle_generation: expected %0d, got %0d", want.hgen,
                         rsp_handle_generation);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  error_count++;
               end
            end
            rsp_wait = $urandom_range(0, 7);
         end else if (rsp_valid && rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         map_gen[i] = '0;
         dense_val[i] = '0;
         dense_slot[i] = '0;
      end
      map_stamp = '0;
      rebuild_free_list();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_fill_and_drain();
      test_random_mix(600);
      test_fill_and_drain();
      test_random_mix(500);
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d words and checked %0d responses: %0d inserts, %0d erases,",
               word_count, answer_count, insert_ok_count, erase_ok_count);
      $display("%0d full-table and %0d invalid-handle answers.", full_count, invalid_count);
      if (error_count == 0 && answers_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gsm_pkg.sv
rtl/core/gsm_ram.sv
rtl/core/gsm_ctrl.sv
rtl/core/gsm_datapath.sv
rtl/core/generational_slot_map_top.sv
rtl/core/gsm_checker.sv
sim/tb_top.sv
